// ===== hw/rtl/bsra_pkg.sv =====
// ----------------------------------------------------------------------------
// bsra_pkg
// shared constants and types for the bitmap store with range query
// ----------------------------------------------------------------------------
`default_nettype none

package bsra_pkg;

    localparam int NUM_BITS   = 65536;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int INDEX_W    = 16;
    localparam int BOUND_W    = 17;
    localparam int COUNT_W    = ADDR_W + 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    waddr_t;
    typedef logic [BIT_W-1:0]     wbit_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_GET   = 2'd1,
        CMD_SET   = 2'd2,
        CMD_ANY   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_GET,
        ST_SET,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_store_range_any.sv =====
// ----------------------------------------------------------------------------
// bitmap_store_range_any
// 64 Kbit bitmap in a 2048 x 32 memory with get, set, prefix clear and
// "any bit set in [left, right)" query
// ----------------------------------------------------------------------------
//  channel | handshake             | beat
//  req     | req_valid, req_ready  | command, bit_index, upper_bound, bit_value
//  rsp     | rsp_valid, rsp_ready  | answer, from_range_query, out_of_range
//
//  after reset a clearing pass writes all 2048 words, one a cycle; no beat is
//  taken until it ends
//  get reads the word, picks the bit in ST_GET and returns it via ST_RESULT;
//  set reads the word and writes it back in ST_SET; clear zeroes words from 0 on
//  up to the word that holds bit upper_bound - 1; any reads one word a cycle from
//  the word of bit_index, the scan stops at the first hit or its last word; a
//  waiting result holds the block until rsp_ready takes it
`default_nettype none

module bitmap_store_range_any
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output      logic                         req_ready,
    input  wire logic [1:0]                   command,
    input  wire logic [bsra_pkg::INDEX_W-1:0] bit_index,
    input  wire logic [bsra_pkg::BOUND_W-1:0] upper_bound,
    input  wire logic                         bit_value,
    output      logic                         rsp_valid,
    input  wire logic                         rsp_ready,
    output      logic                         answer,
    output      logic                         from_range_query,
    output      logic                         out_of_range
);

    localparam int BSUM_W = bsra_pkg::BOUND_W + 1;

    bsra_pkg::word_t  mem [bsra_pkg::NUM_WORDS];
    bsra_pkg::word_t  rd_data_reg;

    bsra_pkg::state_t state_reg, state_next;
    bsra_pkg::waddr_t addr_reg, addr_next;
    bsra_pkg::waddr_t last_reg, last_next;
    bsra_pkg::wbit_t  lo_reg, lo_next;
    bsra_pkg::wbit_t  hi_reg, hi_next;
    logic             first_reg, first_next;
    logic             val_reg, val_next;
    logic             res_answer_reg, res_answer_next;
    logic             res_range_reg, res_range_next;
    logic             res_oor_reg, res_oor_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             answer_reg, answer_next;
    logic             range_reg, range_next;
    logic             oor_reg, oor_next;

    logic             rd_en;
    bsra_pkg::waddr_t rd_addr;
    logic             wr_en;
    bsra_pkg::waddr_t wr_addr;
    bsra_pkg::word_t  wr_data;

    logic                           accept;
    bsra_pkg::cmd_t                 cmd;
    logic [bsra_pkg::BOUND_W-1:0]   ub_sat;
    logic [BSUM_W-1:0]              ub_sum;
    logic [bsra_pkg::COUNT_W-1:0]   clr_words;
    logic [bsra_pkg::BOUND_W-1:0]   ub_dec;
    logic [bsra_pkg::BOUND_W-1:0]   idx_ext;
    bsra_pkg::word_t                scan_mask;
    bsra_pkg::word_t                set_word;
    logic                           slot_free;

    assign accept    = req_valid && req_ready;
    assign cmd       = bsra_pkg::cmd_t'(command);
    assign idx_ext   = bsra_pkg::BOUND_W'(bit_index);
    assign ub_sat    = (upper_bound > bsra_pkg::BOUND_W'(bsra_pkg::NUM_BITS))
                     ? bsra_pkg::BOUND_W'(bsra_pkg::NUM_BITS) : upper_bound;
    assign ub_sum    = BSUM_W'(ub_sat) + BSUM_W'(bsra_pkg::WORD_BITS - 1);
    assign clr_words = ub_sum[bsra_pkg::BIT_W +: bsra_pkg::COUNT_W];
    assign ub_dec    = upper_bound - bsra_pkg::BOUND_W'(1);
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // bits of the current word that lie inside the queried range
    always_comb
    begin
        scan_mask = '1;
        if (first_reg)
        begin
            scan_mask = scan_mask & (bsra_pkg::word_t'('1) << lo_reg);
        end
        if (addr_reg == last_reg)
        begin
            scan_mask = scan_mask
                      & (bsra_pkg::word_t'('1)
                         >> (bsra_pkg::BIT_W'(bsra_pkg::WORD_BITS - 1) - hi_reg));
        end
    end

    always_comb
    begin
        set_word          = rd_data_reg;
        set_word[lo_reg]  = val_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        first_next      = first_reg;
        val_next        = val_reg;
        res_answer_next = res_answer_reg;
        res_range_next  = res_range_reg;
        res_oor_next    = res_oor_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        answer_next     = answer_reg;
        range_next      = range_reg;
        oor_next        = oor_reg;
        req_ready       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '0;

        case (state_reg)
            bsra_pkg::ST_INIT:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + bsra_pkg::waddr_t'(1);
                if (addr_reg == bsra_pkg::waddr_t'(bsra_pkg::NUM_WORDS - 1))
                begin
                    state_next = bsra_pkg::ST_IDLE;
                end
            end

            bsra_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                addr_next = bit_index[bsra_pkg::BIT_W +: bsra_pkg::ADDR_W];
                lo_next   = bit_index[bsra_pkg::BIT_W-1:0];
                hi_next   = ub_dec[bsra_pkg::BIT_W-1:0];
                last_next = ub_dec[bsra_pkg::BIT_W +: bsra_pkg::ADDR_W];
                val_next  = bit_value;
                first_next = 1'b1;
                rd_addr   = bit_index[bsra_pkg::BIT_W +: bsra_pkg::ADDR_W];
                if (accept)
                begin
                    case (cmd)
                        bsra_pkg::CMD_CLEAR:
                        begin
                            addr_next = '0;
                            last_next = clr_words[bsra_pkg::ADDR_W-1:0]
                                      - bsra_pkg::waddr_t'(1);
                            if (clr_words != '0)
                            begin
                                state_next = bsra_pkg::ST_CLEAR;
                            end
                        end
                        bsra_pkg::CMD_GET:
                        begin
                            rd_en      = 1'b1;
                            state_next = bsra_pkg::ST_GET;
                        end
                        bsra_pkg::CMD_SET:
                        begin
                            if (idx_ext < bsra_pkg::BOUND_W'(bsra_pkg::NUM_BITS))
                            begin
                                rd_en      = 1'b1;
                                state_next = bsra_pkg::ST_SET;
                            end
                        end
                        default:
                        begin
                            res_range_next = 1'b1;
                            res_answer_next = 1'b0;
                            res_oor_next   = 1'b0;
                            if (idx_ext >= bsra_pkg::BOUND_W'(bsra_pkg::NUM_BITS)
                                || upper_bound > bsra_pkg::BOUND_W'(bsra_pkg::NUM_BITS))
                            begin
                                res_oor_next = 1'b1;
                                state_next   = bsra_pkg::ST_RESULT;
                            end
                            else if (upper_bound <= idx_ext)
                            begin
                                state_next = bsra_pkg::ST_RESULT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = bsra_pkg::ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            bsra_pkg::ST_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + bsra_pkg::waddr_t'(1);
                if (addr_reg == last_reg)
                begin
                    state_next = bsra_pkg::ST_IDLE;
                end
            end

            bsra_pkg::ST_GET:
            begin
                res_answer_next = rd_data_reg[lo_reg];
                res_range_next  = 1'b0;
                res_oor_next    = 1'b0;
                state_next      = bsra_pkg::ST_RESULT;
            end

            bsra_pkg::ST_SET:
            begin
                wr_en      = 1'b1;
                wr_data    = set_word;
                state_next = bsra_pkg::ST_IDLE;
            end

            bsra_pkg::ST_SCAN:
            begin
                first_next = 1'b0;
                if ((rd_data_reg & scan_mask) != '0)
                begin
                    res_answer_next = 1'b1;
                    state_next      = bsra_pkg::ST_RESULT;
                end
                else if (addr_reg == last_reg)
                begin
                    state_next = bsra_pkg::ST_RESULT;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + bsra_pkg::waddr_t'(1);
                    addr_next = addr_reg + bsra_pkg::waddr_t'(1);
                end
            end

            bsra_pkg::ST_RESULT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    answer_next    = res_answer_reg;
                    range_next     = res_range_reg;
                    oor_next       = res_oor_reg;
                    state_next     = bsra_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bsra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsra_pkg::ST_INIT;
            addr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        first_reg      <= first_next;
        val_reg        <= val_next;
        res_answer_reg <= res_answer_next;
        res_range_reg  <= res_range_next;
        res_oor_reg    <= res_oor_next;
        answer_reg     <= answer_next;
        range_reg      <= range_next;
        oor_reg        <= oor_next;
    end

    assign rsp_valid        = rsp_valid_reg;
    assign answer           = answer_reg;
    assign from_range_query = range_reg;
    assign out_of_range     = oor_reg;

`ifndef SYNTH
    a_no_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsra_pkg::ST_IDLE) |-> !wr_en)
        else $error("memory written while idle");

    a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsra_pkg::ST_SCAN) |-> (addr_reg <= last_reg))
        else $error("range scan ran past its last word");

    a_get_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !from_range_query) |-> !out_of_range)
        else $error("get flagged out of range");

    a_oor_answer : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_of_range) |-> !answer)
        else $error("out of range result with answer set");

    a_result_after_scan : assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == bsra_pkg::ST_RESULT && state_reg == bsra_pkg::ST_IDLE)
        |-> rsp_valid)
        else $error("result state left without presenting a beat");
`endif

endmodule

`default_nettype wire
